@@ hw/rtl/uart_rx_ring_buffer_flow_control_macros.svh @@
// ----------------------------------------------------------------------------
// UART receive ring buffer assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef UART_RX_RING_BUFFER_FLOW_CONTROL_MACROS_SVH
`define UART_RX_RING_BUFFER_FLOW_CONTROL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define URBFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define URBFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/urbfc_pkg.sv @@
// ----------------------------------------------------------------------------
// UART receive ring buffer package
// Shared constants, codes and control structures.
// ----------------------------------------------------------------------------
`default_nettype none

package urbfc_pkg;

  // Default and upper limit of the slot store.
  localparam int URBFC_DEPTH      = 256;
  localparam int URBFC_SLOT_LIMIT = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_XOFF_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_XON_CODE  = 3'd4;

  // Flow control modes; the unused code behaves as no flow control.
  localparam logic [1:0] FLOW_NONE    = 2'd0;
  localparam logic [1:0] FLOW_XONXOFF = 2'd1;
  localparam logic [1:0] FLOW_RTSCTS  = 2'd2;

  // Commands.
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Register reset values.
  localparam logic [1:0] RST_FLOW_MODE = FLOW_NONE;
  localparam logic [8:0] RST_HEADROOM  = 9'd16;
  localparam logic [8:0] RST_BUF_SIZE  = 9'd256;
  localparam logic [7:0] RST_XOFF_CODE = 8'd19;
  localparam logic [7:0] RST_XON_CODE  = 8'd17;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic rd_capture;
    logic load_out;
  } urbfc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic rd_hit;
  } urbfc_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/urbfc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module urbfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/urbfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// UART receive ring buffer controller
// Sequences transfers via execute, read wait on a hit, and result hand-over.
// ----------------------------------------------------------------------------
`default_nettype none

module urbfc_ctrl import urbfc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire urbfc_status_t status,
  output urbfc_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_WAIT,
    S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd.accept     = (state_r == S_IDLE) && in_valid;
    cmd.rd_capture = (state_r == S_RD_WAIT);
    cmd.load_out   = (state_r == S_HOLD) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = status.rd_hit ? S_RD_WAIT : S_HOLD;
        end
      end
      S_RD_WAIT: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hw/rtl/urbfc_dp.sv @@
// ----------------------------------------------------------------------------
// UART receive ring buffer datapath
// Configuration registers, ring indexes, slot memory and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module urbfc_dp import urbfc_pkg::*; #(
  parameter int DEPTH = URBFC_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_command,
  input  wire logic [7:0]            in_rx_byte,
  input  wire urbfc_cmd_t            cmd,
  output urbfc_status_t              status,
  output logic                       out_read_valid,
  output logic [7:0]                 out_read_data,
  output logic                       out_stored,
  output logic                       out_overrun,
  output logic [8:0]                 out_free_space,
  output logic                       out_send_xoff,
  output logic                       out_drop_rts,
  output logic                       out_tx_enabled,
  output logic                       out_tx_kick
);

  localparam int MEM_DEPTH = (DEPTH < URBFC_SLOT_LIMIT) ? DEPTH : URBFC_SLOT_LIMIT;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int SW        = $clog2(MEM_DEPTH + 1);
  localparam logic [8:0] SIZE_MAX = 9'(MEM_DEPTH);
  localparam logic [8:0] SIZE_MIN = 9'd2;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                            input logic [SW-1:0] size);
    logic [SW-1:0] inc;
    inc = SW'(idx) + SW'(1);
    return (inc >= size) ? '0 : AW'(inc);
  endfunction

  function automatic logic [SW-1:0] free_count(input logic [AW-1:0] hd,
                                               input logic [AW-1:0] tl,
                                               input logic [SW-1:0] size);
    logic [SW-1:0] h;
    logic [SW-1:0] t;
    h = SW'(hd);
    t = SW'(tl);
    return (h >= t) ? (size - (h - t)) : (t - h);
  endfunction

  // Configuration registers.
  logic [1:0] flow_mode_r;
  logic [8:0] headroom_r;
  logic [8:0] buf_size_r;
  logic [7:0] xoff_code_r;
  logic [7:0] xon_code_r;

  // Ring state.
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          peer_r, peer_nxt;

  // Staged result.
  logic       res_read_valid_r;
  logic [7:0] res_read_data_r;
  logic       res_stored_r;
  logic       res_overrun_r;
  logic [8:0] res_free_space_r;
  logic       res_send_xoff_r;
  logic       res_drop_rts_r;
  logic       res_tx_enabled_r;
  logic       res_tx_kick_r;

  // Output register.
  logic       out_read_valid_r;
  logic [7:0] out_read_data_r;
  logic       out_stored_r;
  logic       out_overrun_r;
  logic [8:0] out_free_space_r;
  logic       out_send_xoff_r;
  logic       out_drop_rts_r;
  logic       out_tx_enabled_r;
  logic       out_tx_kick_r;

  logic [8:0]    size_clamp;
  logic [SW-1:0] size_eff;
  logic [AW-1:0] head_n;
  logic [AW-1:0] tail_n;
  logic [SW-1:0] free_pre;
  logic [SW-1:0] free_post;
  logic          is_read;
  logic          hit;
  logic          is_flow_byte;
  logic          flow_store;
  logic          step_we;
  logic          step_re;
  logic          step_rv;
  logic          step_st;
  logic          step_ov;
  logic          step_kick;
  logic          flow_req;
  logic [7:0]    ram_rdata;

  always_comb begin
    size_clamp = buf_size_r;
    if (buf_size_r < SIZE_MIN) begin
      size_clamp = SIZE_MIN;
    end else if (buf_size_r > SIZE_MAX) begin
      size_clamp = SIZE_MAX;
    end
    size_eff = SW'(size_clamp);
  end

  // Indexes left beyond a shrunk buffer restart at slot zero.
  assign head_n   = (SW'(head_r) >= size_eff) ? '0 : head_r;
  assign tail_n   = (SW'(tail_r) >= size_eff) ? '0 : tail_r;
  assign free_pre = free_count(head_n, tail_n, size_eff);

  assign is_read      = (in_command == CMD_READ);
  assign hit          = (head_n != tail_n);
  assign is_flow_byte = (flow_mode_r == FLOW_XONXOFF) &&
                        ((in_rx_byte == xoff_code_r) || (in_rx_byte == xon_code_r));

  always_comb begin
    head_nxt   = head_n;
    tail_nxt   = tail_n;
    peer_nxt   = peer_r;
    step_we    = 1'b0;
    step_re    = 1'b0;
    step_rv    = 1'b0;
    step_st    = 1'b0;
    step_ov    = 1'b0;
    step_kick  = 1'b0;
    flow_store = 1'b0;
    if (is_read) begin
      if (hit) begin
        step_rv  = 1'b1;
        step_re  = 1'b1;
        tail_nxt = advance(tail_n, size_eff);
      end
    end else if (is_flow_byte) begin
      // XOFF wins when both codes are equal.
      if (in_rx_byte == xoff_code_r) begin
        peer_nxt = 1'b0;
      end else if (!peer_r) begin
        peer_nxt  = 1'b1;
        step_kick = 1'b1;
      end
    end else if ((flow_mode_r == FLOW_XONXOFF) || (flow_mode_r == FLOW_RTSCTS)) begin
      step_we    = 1'b1;
      flow_store = 1'b1;
      if (free_pre > SW'(1)) begin
        head_nxt = advance(head_n, size_eff);
        step_st  = 1'b1;
      end else begin
        step_ov  = 1'b1;
      end
    end else begin
      step_we  = 1'b1;
      head_nxt = advance(head_n, size_eff);
      step_st  = 1'b1;
    end
  end

  assign free_post = free_count(head_nxt, tail_nxt, size_eff);
  assign flow_req  = flow_store && (9'(free_post) <= headroom_r);

  assign status.rd_hit = is_read && hit;

  urbfc_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (cmd.accept && step_we),
    .wr_addr (head_n),
    .wr_data (in_rx_byte),
    .rd_en   (cmd.accept && step_re),
    .rd_addr (tail_n),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_mode_r <= RST_FLOW_MODE;
      headroom_r  <= RST_HEADROOM;
      buf_size_r  <= RST_BUF_SIZE;
      xoff_code_r <= RST_XOFF_CODE;
      xon_code_r  <= RST_XON_CODE;
      head_r      <= '0;
      tail_r      <= '0;
      peer_r      <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FLOW_MODE: flow_mode_r <= cfg_wdata[1:0];
          CFG_HEADROOM:  headroom_r  <= cfg_wdata;
          CFG_BUF_SIZE:  buf_size_r  <= cfg_wdata;
          CFG_XOFF_CODE: xoff_code_r <= cfg_wdata[7:0];
          CFG_XON_CODE:  xon_code_r  <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        peer_r <= peer_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_read_valid_r <= step_rv;
      res_read_data_r  <= '0;
      res_stored_r     <= step_st;
      res_overrun_r    <= step_ov;
      res_free_space_r <= 9'(free_post);
      res_send_xoff_r  <= flow_req && (flow_mode_r == FLOW_XONXOFF);
      res_drop_rts_r   <= flow_req && (flow_mode_r == FLOW_RTSCTS);
      res_tx_enabled_r <= peer_nxt;
      res_tx_kick_r    <= step_kick;
    end else if (cmd.rd_capture) begin
      res_read_data_r  <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_read_valid_r <= res_read_valid_r;
      out_read_data_r  <= res_read_data_r;
      out_stored_r     <= res_stored_r;
      out_overrun_r    <= res_overrun_r;
      out_free_space_r <= res_free_space_r;
      out_send_xoff_r  <= res_send_xoff_r;
      out_drop_rts_r   <= res_drop_rts_r;
      out_tx_enabled_r <= res_tx_enabled_r;
      out_tx_kick_r    <= res_tx_kick_r;
    end
  end

  assign out_read_valid = out_read_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_stored     = out_stored_r;
  assign out_overrun    = out_overrun_r;
  assign out_free_space = out_free_space_r;
  assign out_send_xoff  = out_send_xoff_r;
  assign out_drop_rts   = out_drop_rts_r;
  assign out_tx_enabled = out_tx_enabled_r;
  assign out_tx_kick    = out_tx_kick_r;

endmodule

`default_nettype wire

@@ hw/rtl/uart_rx_ring_buffer_flow_control.sv @@
// ----------------------------------------------------------------------------
// UART receive ring buffer with flow control
// Receive FIFO behind a UART with XON/XOFF or RTS/CTS receive flow control.
// ----------------------------------------------------------------------------
// Each input transfer offers a received byte for storage (command 0) or asks
// to pop one byte for the consumer (command 1), and every transfer yields
// exactly one result transfer. A store or a read of an empty buffer goes
// through the hold state back to idle; a read that finds data first passes the
// read-wait state, for the registered read port of the slot memory. A finished
// result waits in a staging register while the output register is stalled, so
// one further transfer is accepted and worked on before the input side stalls.
// The slot memory needs no clearing pass after reset: slots are only read once
// written, except after the buffer size has been changed, when stale slots may
// be returned. The buffer size register is clamped to between two and the
// smaller of DEPTH and 256 slots. The user must write configuration only while
// no transfer is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rx_ring_buffer_flow_control import urbfc_pkg::*; #(
  parameter int DEPTH = URBFC_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_command,
  input  wire logic [7:0]            in_rx_byte,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_read_valid,
  output logic [7:0]                 out_read_data,
  output logic                       out_stored,
  output logic                       out_overrun,
  output logic [8:0]                 out_free_space,
  output logic                       out_send_xoff,
  output logic                       out_drop_rts,
  output logic                       out_tx_enabled,
  output logic                       out_tx_kick
);

  urbfc_cmd_t    cmd;
  urbfc_status_t status;

  // The controller decides when a transfer is taken and when its result moves
  // to the output register; the datapath does the ring arithmetic.
  urbfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  urbfc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_command     (in_command),
    .in_rx_byte     (in_rx_byte),
    .cmd            (cmd),
    .status         (status),
    .out_read_valid (out_read_valid),
    .out_read_data  (out_read_data),
    .out_stored     (out_stored),
    .out_overrun    (out_overrun),
    .out_free_space (out_free_space),
    .out_send_xoff  (out_send_xoff),
    .out_drop_rts   (out_drop_rts),
    .out_tx_enabled (out_tx_enabled),
    .out_tx_kick    (out_tx_kick)
  );

endmodule

`default_nettype wire

@@ hw/rtl/urbfc_chk.sv @@
// ----------------------------------------------------------------------------
// UART receive ring buffer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_rx_ring_buffer_flow_control_macros.svh"

module urbfc_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_read_valid,
  input wire logic [7:0] out_read_data,
  input wire logic       out_stored,
  input wire logic       out_overrun,
  input wire logic [8:0] out_free_space,
  input wire logic       out_send_xoff,
  input wire logic       out_drop_rts,
  input wire logic       out_tx_enabled,
  input wire logic       out_tx_kick
);

  // Any result without read data, a read miss included, must carry zero data.
  `URBFC_ASSERT_IMPLY(a_miss_zero, clk, rst_n, out_valid && !out_read_valid,
                      out_read_data == 8'd0, "read miss with non-zero data")

  // A successful read carries no store, overrun, kick or flow-off flags.
  `URBFC_ASSERT_IMPLY(a_read_clean, clk, rst_n, out_valid && out_read_valid,
                      !out_stored && !out_overrun && !out_tx_kick &&
                      !out_send_xoff && !out_drop_rts,
                      "read result carries receive flags")

  // A kick always leaves the transmitter enabled.
  `URBFC_ASSERT_IMPLY(a_kick_enabled, clk, rst_n, out_valid && out_tx_kick,
                      out_tx_enabled, "transmitter kicked but not enabled")

  // Stored and overrun are exclusive, as are the two flow-off requests.
  `URBFC_ASSERT_IMPLY(a_flags_excl, clk, rst_n, out_valid,
                      !(out_stored && out_overrun) && !(out_send_xoff && out_drop_rts),
                      "exclusive result flags both set")

  // A stalled result stays presented.
  `URBFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                     out_valid && $stable(out_free_space), "stalled result changed")

endmodule

bind uart_rx_ring_buffer_flow_control urbfc_chk u_urbfc_chk (.*);

`default_nettype wire
